### rtl/core/cpf_pkg.sv
// Shared types, constants and the CRC-16 byte fold for the packet framer.
// No dependencies; every other file in rtl/core but cpf_fifo imports this package.
`default_nettype none

package cpf_pkg;

    // framing constants
    localparam logic [7:0]  SYNC_BYTE   = 8'h55;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam int          JOB_BYTES   = 8;
    localparam int          JOB_IDX_W   = $clog2(JOB_BYTES);
    localparam int          QUEUE_DEPTH = 4;

    // one queued job: up to eight bytes to send, first byte at index 0
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [JOB_IDX_W-1:0]      last_idx;
        logic                      has_end;
    } t_job;

    // CRC-16/XMODEM, MSB first, one byte folded in
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/crc16_packet_framer.sv
// Top level of the CRC-16 packet framer: front end, job queue, back end.
// Depends on cpf_pkg, cpf_front, cpf_fifo and cpf_back.
//
// Each input beat is accepted while the job queue has room. A start beat
// yields a header of six bytes (sync 0x55, command, length+2 big-endian) plus the
// trailer 00 00 when the command or length is zero; a payload beat of an open
// packet yields one byte, or three on its last byte (data, CRC high, CRC low).
// The output side sends one byte per cycle while i_out_ready is high, so payload
// streams at one beat per cycle, and the queue of QUEUE_DEPTH jobs lets the input
// keep accepting while a header occupies the output. Each byte is registered in
// the job queue and then in the output register. With the link register clear,
// nothing is emitted, though payload still advances the open packet's CRC and count.
`default_nettype none

module crc16_packet_framer #(
    parameter int QUEUE_DEPTH = cpf_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_wr_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_mode,
    input  wire [7:0]   i_command,
    input  wire [23:0]  i_packet_length,
    input  wire [7:0]   i_data_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end
);
    import cpf_pkg::*;

    t_job             push_job, head_job;
    logic [$bits(t_job)-1:0] head_bits;
    logic             push, pop, q_full, q_empty;

    assign head_job = t_job'(head_bits);

    // front: classify beats, update CRC state
    cpf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_command       (i_command),
        .i_packet_length (i_packet_length),
        .i_data_byte     (i_data_byte),
        .i_queue_full    (q_full),
        .o_push          (push),
        .o_job           (push_job)
    );

    // job queue
    cpf_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (push_job),
        .i_pop     (pop),
        .o_rd_data (head_bits),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // back: byte serializer
    cpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_empty (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire

### rtl/core/cpf_front.sv
// Front end: accepts input beats, tracks packet state and CRC, and builds jobs.
// Depends on cpf_pkg.
`default_nettype none

module cpf_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_wr_en,
    input  wire               i_cfg_wr_data,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire               i_mode,
    input  wire [7:0]         i_command,
    input  wire [23:0]        i_packet_length,
    input  wire [7:0]         i_data_byte,
    input  wire               i_queue_full,
    output logic              o_push,
    output cpf_pkg::t_job     o_job
);
    import cpf_pkg::*;

    logic        r_link;
    logic [15:0] r_crc, n_crc;
    logic [23:0] r_left, n_left;
    logic        r_open, n_open;

    logic        accept;
    logic [31:0] announced;
    logic [15:0] crc_next;
    logic [23:0] left_dec;
    logic        short_hdr;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign announced  = {8'h00, i_packet_length} + 32'd2;
    assign crc_next   = crc_fold(r_crc, i_data_byte);
    assign left_dec   = r_left - 24'd1;
    assign short_hdr  = (i_command == 8'h00) || (i_packet_length == 24'd0);

    // classify the beat and form the job and next packet state
    always_comb begin
        n_crc  = r_crc;
        n_left = r_left;
        n_open = r_open;
        o_push = 1'b0;
        o_job  = '0;
        if (accept) begin
            if (!i_mode) begin
                if (r_link) begin
                    o_push = 1'b1;
                    o_job.bytes = {8'h00, 8'h00, announced[7:0], announced[15:8],
                                   announced[23:16], announced[31:24], i_command, SYNC_BYTE};
                    o_job.last_idx = short_hdr ? JOB_IDX_W'(7) : JOB_IDX_W'(5);
                    o_job.has_end  = short_hdr;
                    n_crc  = 16'h0000;
                    n_left = short_hdr ? 24'd0 : i_packet_length;
                    n_open = !short_hdr;
                end
            end else if (r_open) begin
                n_crc  = crc_next;
                n_left = left_dec;
                if (left_dec == 24'd0) begin
                    n_open = 1'b0;
                end
                // payload state advances even with the link down
                o_push = r_link;
                o_job.bytes[0] = i_data_byte;
                o_job.bytes[1] = crc_next[15:8];
                o_job.bytes[2] = crc_next[7:0];
                o_job.last_idx = (left_dec == 24'd0) ? JOB_IDX_W'(2) : JOB_IDX_W'(0);
                o_job.has_end  = (left_dec == 24'd0);
            end
        end
    end

    // packet state and link register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= 1'b0;
            r_crc  <= 16'h0000;
            r_left <= 24'd0;
            r_open <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_link <= i_cfg_wr_data;
            end
            r_crc  <= n_crc;
            r_left <= n_left;
            r_open <= n_open;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cpf_fifo.sv
// Job queue between front and back ends, flip-flop storage.
// Does not depend on cpf_pkg; width and depth are parameters.
`default_nettype none

module cpf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_wr_data,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

### rtl/core/cpf_back.sv
// Back end: serializes queued jobs into output byte beats through an output register.
// Depends on cpf_pkg.
`default_nettype none

module cpf_back (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  cpf_pkg::t_job  i_job,
    input  wire            i_job_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_frame_end
);
    import cpf_pkg::*;

    logic [JOB_IDX_W-1:0] r_idx;
    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_end;
    logic                 load;
    logic                 at_last;

    assign load        = !r_valid || i_out_ready;
    assign at_last     = (r_idx == i_job.last_idx);
    assign o_pop       = load && !i_job_empty && at_last;
    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_end;

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load && !i_job_empty) begin
            r_byte <= i_job.bytes[r_idx];
            r_end  <= i_job.has_end && at_last;
        end
    end

    // byte index within the head job and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= !i_job_empty;
            if (!i_job_empty) begin
                r_idx <= at_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    a_mid_job_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> !i_job_empty) else $error("job index advanced with no job at head");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for crc16_packet_framer: random and directed beats with a
// CRC-16/XMODEM framing predictor and a byte-stream scoreboard.
// Depends on the RTL under rtl/core (the framer top level and the modules under it).
`timescale 1ns / 1ps

module testbench;

    localparam bit          MODE_START   = 1'b0;
    localparam bit          MODE_PAYLOAD = 1'b1;
    localparam logic [7:0]  SYNC_MARK    = 8'h55;
    localparam logic [15:0] XMODEM_POLY  = 16'h1021;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          PHASE_BEATS  = 35;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_framed_byte;

    // Framing predictor plus the queue of bytes it says must come out
    class framer_scoreboard;
        t_framed_byte stream_q[$];
        bit           link_up;
        bit [15:0]    crc;
        bit [23:0]    left;
        bit           in_packet;
        int           mismatches;
        int           bytes_checked;

        function void push(logic [7:0] v, logic last);
            t_framed_byte fb;
            fb.value = v;
            fb.last  = last;
            stream_q.push_back(fb);
        endfunction

        // bitwise XMODEM update, MSB of the data first
        function bit [15:0] crc_step(bit [15:0] c, bit [7:0] d);
            bit fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ d[i];
                c  = {c[14:0], 1'b0};
                if (fb) c = c ^ XMODEM_POLY;
            end
            return c;
        endfunction

        // returns 1 when the beat changed state or produced bytes
        function bit note_beat(bit mode, bit [7:0] cmd, bit [23:0] len, bit [7:0] data);
            bit [31:0] announced;
            if (mode == MODE_START) begin
                if (!link_up) return 0;
                announced = {8'h00, len} + 32'd2;
                in_packet = 0;
                crc       = 16'h0000;
                push(SYNC_MARK, 0);
                push(cmd, 0);
                push(announced[31:24], 0);
                push(announced[23:16], 0);
                push(announced[15:8], 0);
                push(announced[7:0], 0);
                if (cmd == 8'h00 || len == 24'h0) begin
                    left = 24'h0;
                    push(8'h00, 0);
                    push(8'h00, 1);
                end else begin
                    left      = len;
                    in_packet = 1;
                end
                return 1;
            end
            if (!in_packet) return 0;
            crc  = crc_step(crc, data);
            left = left - 24'd1;
            if (link_up) push(data, 0);
            if (left == 24'h0) begin
                in_packet = 0;
                if (link_up) begin
                    push(crc[15:8], 0);
                    push(crc[7:0], 1);
                end
            end
            return 1;
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_byte(logic [7:0] v, logic last);
            t_framed_byte want;
            bytes_checked++;
            if (stream_q.size() == 0) begin
                report($sformatf("unexpected byte %02h frame_end %0b", v, last));
                return;
            end
            want = stream_q.pop_front();
            if (v !== want.value)
                report($sformatf("out_byte %02h, wanted %02h", v, want.value));
            if (last !== want.last)
                report($sformatf("frame_end %0b, wanted %0b (byte %02h)", last, want.last, v));
        endtask
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic        i_cfg_wr_data   = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        i_mode          = 1'b0;
    logic [7:0]  i_command       = 8'h00;
    logic [23:0] i_packet_length = 24'h0;
    logic [7:0]  i_data_byte     = 8'h00;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_frame_end;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int beats_sent    = 0;
    int beats_applied = 0;
    framer_scoreboard sb;

    crc16_packet_framer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_command       (i_command),
        .i_packet_length (i_packet_length),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_frame_end     (o_frame_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // output side: check each beat taken, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_byte(o_out_byte, o_frame_end);
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one input beat, with optional idle cycles ahead of it
    task automatic send_beat(bit mode, bit [7:0] cmd, bit [23:0] len, bit [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_command       <= cmd;
        i_packet_length <= len;
        i_data_byte     <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
        if (sb.note_beat(mode, cmd, len, data)) beats_applied++;
    endtask

    // unused fields carry random junk
    task automatic send_start(bit [7:0] cmd, bit [23:0] len);
        send_beat(MODE_START, cmd, len, 8'($urandom));
    endtask

    task automatic send_payload(bit [7:0] data);
        send_beat(MODE_PAYLOAD, 8'($urandom), 24'($urandom), data);
    endtask

    // let every expected byte drain, then give the queue time to empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.stream_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_link(bit up);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= up;
        @(posedge i_clk);
        sb.link_up = up;
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed packets; the rest header-only, empty, stray or abandoned
    task automatic random_packet();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 70) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_start(8'($urandom_range(1, 255)), 24'(n));
            repeat (n) send_payload(8'($urandom));
        end else if (pick < 78) begin
            send_start(8'h00, 24'($urandom));
        end else if (pick < 84) begin
            send_start(8'($urandom_range(1, 255)), 24'h0);
        end else if (pick < 90) begin
            send_payload(8'($urandom));
        end else begin
            send_start(8'($urandom_range(1, 255)), 24'($urandom) | 24'h000100);
            repeat ($urandom_range(3)) send_payload(8'($urandom));
        end
    endtask

    task automatic run_phase();
        int first;
        first = beats_applied;
        while (beats_applied - first < PHASE_BEATS) random_packet();
    endtask

    // packet whose middle goes through with the link down
    task automatic link_drop_packet();
        int n;
        int a;
        int b;
        n = $urandom_range(3, 10);
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - a - 1);
        send_start(8'($urandom_range(1, 255)), 24'(n));
        repeat (a) send_payload(8'($urandom));
        wait_idle();
        set_link(1'b0);
        repeat (b) send_payload(8'($urandom));
        send_start(8'($urandom_range(1, 255)), 24'($urandom));
        wait_idle();
        set_link(1'b1);
        repeat (n - a - b) send_payload(8'($urandom));
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // link down from reset: start ignored, stray payload dropped
        send_start(8'hAA, 24'd3);
        send_payload(8'h12);
        wait_idle();
        set_link(1'b1);

        send_payload(8'hFF);
        send_start(8'h00, 24'h000000);
        send_start(8'h00, 24'hFFFFFF);
        send_start(8'hFF, 24'h000000);
        send_start(8'h01, 24'hFFFFFE);
        // full packet, then a payload after it closed
        send_start(8'h80, 24'd3);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'hA5);
        send_payload(8'h3C);
        // open packet abandoned by a new start
        send_start(8'h42, 24'd2);
        send_payload(8'h31);
        send_start(8'h7F, 24'd1);
        send_payload(8'h5A);
        // link drops mid-packet; CRC keeps folding, start ignored
        send_start(8'h10, 24'd4);
        send_payload(8'h01);
        send_payload(8'h02);
        wait_idle();
        set_link(1'b0);
        send_payload(8'h03);
        send_start(8'h99, 24'd5);
        wait_idle();
        set_link(1'b1);
        send_payload(8'h04);

        send_idle_pct = 21;
        recv_idle_pct = 88;
        run_phase();
        link_drop_packet();

        send_idle_pct = 88;
        recv_idle_pct = 21;
        run_phase();
        link_drop_packet();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase();
        wait_idle();

        $display("summary: %0d input beats (%0d effective), %0d output bytes checked,",
                 beats_sent, beats_applied, sb.bytes_checked);
        $display("summary: link up/down toggles, three idle mixes, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### crc16_packet_framer.f
rtl/core/cpf_pkg.sv
rtl/core/cpf_front.sv
rtl/core/cpf_fifo.sv
rtl/core/cpf_back.sv
rtl/core/crc16_packet_framer.sv
tb/testbench.sv
